### hdl/cvls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvls_pkg
// Shared types and constants of the composite video line slicer.
// ----------------------------------------------------------------------------
package cvls_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SYNC_THRESHOLD  = 3'd0,
        REG_MIN_LINE_LENGTH = 3'd1,
        REG_BLACK_LEVEL     = 3'd2,
        REG_WHITE_LEVEL     = 3'd3,
        REG_FRAME_WIDTH     = 3'd4,
        REG_FRAME_HEIGHT    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] sync_threshold;
        logic        [15:0] min_line_length;
        logic signed [15:0] black_level;
        logic signed [15:0] white_level;
        logic        [10:0] frame_width;
        logic        [10:0] frame_height;
    } cfg_t;

    localparam logic signed [15:0] SYNC_THRESHOLD_RESET  = 16'sd2048;
    localparam int                 MIN_LINE_LENGTH_RESET = 386;
    localparam logic signed [15:0] BLACK_LEVEL_RESET     = 16'sd0;
    localparam logic signed [15:0] WHITE_LEVEL_RESET     = 16'sd32767;
    localparam logic        [10:0] FRAME_WIDTH_RESET     = 11'd640;
    localparam logic        [10:0] FRAME_HEIGHT_RESET    = 11'd480;

    // Frame phase: -2..0 wait for blanking, 1 blanking, 2 draw, 3 done.
    localparam logic signed [2:0] PHASE_START = -3'sd2;
    localparam logic signed [2:0] PHASE_BLANK = 3'sd1;
    localparam logic signed [2:0] PHASE_DRAW  = 3'sd2;
    localparam logic signed [2:0] PHASE_STEP  = 3'sd1;

    localparam int GRAY_BITS = 8;
    localparam logic [GRAY_BITS-1:0] GRAY_MAX = 8'd255;

    typedef struct packed {
        logic        [9:0]  row;
        logic        [9:0]  column;
        logic signed [15:0] sample;
    } pixel_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

### hdl/cvls_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvls_stream_if
// Valid/ready channels of the line slicer: video samples in, pixels out.
// ----------------------------------------------------------------------------
interface cvls_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface cvls_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_row;
    logic [9:0] pixel_column;
    logic [7:0] pixel_gray;

    modport source (output valid, output pixel_row, output pixel_column,
                    output pixel_gray, input ready);
    modport sink   (input valid, input pixel_row, input pixel_column,
                    input pixel_gray, output ready);
endinterface
`default_nettype wire

### hdl/cvls_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvls_front
// Sync separation, line length counting and frame phase tracking; pushes one
// pixel job per visible drawing sample.
// ----------------------------------------------------------------------------
module cvls_front
    import cvls_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cvls_in_if.sink            video,
    input  wire cfg_t          cfg,
    input  wire queue_status_t q_status,
    output logic               push,
    output pixel_job_t         push_job
);

    localparam int CW = LINE_COUNT_BITS + 16;
    localparam int LINE_MAX_INT = (1 << LINE_COUNT_BITS) - 1;
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = {LINE_COUNT_BITS{1'b1}};
    localparam logic [LINE_COUNT_BITS-1:0] LINE_RESET =
        (MIN_LINE_LENGTH_RESET > LINE_MAX_INT) ? LINE_MAX
                                               : LINE_COUNT_BITS'(MIN_LINE_LENGTH_RESET);

    logic                       in_sync_reg, in_sync_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;
    logic signed [2:0]          phase_reg, phase_next;
    logic [10:0]                row_reg, row_next;

    logic                       accept;
    logic signed [15:0]         sample_ext;
    logic [CW-1:0]              line_ext, min_ext, width_ext;
    logic [LINE_COUNT_BITS-1:0] restart_len;
    logic                       frame_full, line_short, line_long;
    logic signed [2:0]          phase_step;

    assign video.ready = !q_status.full;
    assign accept      = video.valid && video.ready;
    assign sample_ext  = 16'($signed(video.sample[SAMPLE_BITS-1:0]));

    assign line_ext   = CW'(line_reg);
    assign min_ext    = CW'(cfg.min_line_length);
    assign width_ext  = CW'(cfg.frame_width);
    assign line_short = line_ext < min_ext;
    assign line_long  = line_ext > min_ext;
    assign frame_full = row_reg >= cfg.frame_height;

    // A restart loads the line counter with the threshold length, saturated.
    assign restart_len = (min_ext[CW-1:LINE_COUNT_BITS] != '0) ? LINE_MAX
                                                              : min_ext[LINE_COUNT_BITS-1:0];

    always_comb
    begin
        in_sync_next = in_sync_reg;
        line_next    = line_reg;
        phase_next   = phase_reg;
        row_next     = row_reg;
        phase_step   = phase_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (video.mode)
            begin
                in_sync_next = 1'b0;
                line_next    = restart_len;
                phase_next   = PHASE_START;
                row_next     = '0;
            end
            else if (!frame_full)
            begin
                if (sample_ext < cfg.sync_threshold)
                begin
                    if (!in_sync_reg)
                    begin
                        // The checks run in order; each sees the phase the one
                        // before it left.
                        if (phase_reg == PHASE_DRAW)
                            row_next = row_reg + 11'd1;
                        if (phase_step < PHASE_BLANK && line_short)
                            phase_step = phase_step + PHASE_STEP;
                        if (phase_step == PHASE_BLANK && line_long)
                            phase_step = phase_step + PHASE_STEP;
                        if (phase_step == PHASE_DRAW && line_short)
                            phase_step = phase_step + PHASE_STEP;
                        phase_next = phase_step;
                        line_next  = '0;
                    end
                    in_sync_next = 1'b1;
                end
                else
                begin
                    in_sync_next = 1'b0;
                    push = (phase_reg == PHASE_DRAW) && (line_ext < width_ext);
                    if (line_reg != LINE_MAX)
                        line_next = line_reg + 1'b1;
                end
            end
        end
    end

    assign push_job.row    = row_reg[9:0];
    assign push_job.column = line_reg[9:0];
    assign push_job.sample = sample_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sync_reg <= 1'b0;
            line_reg    <= LINE_RESET;
            phase_reg   <= PHASE_START;
            row_reg     <= '0;
        end
        else
        begin
            in_sync_reg <= in_sync_next;
            line_reg    <= line_next;
            phase_reg   <= phase_next;
            row_reg     <= row_next;
        end
    end

endmodule
`default_nettype wire

### hdl/cvls_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvls_queue
// Two-entry queue of pixel jobs between the front and the divider.
// ----------------------------------------------------------------------------
module cvls_queue
    import cvls_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire pixel_job_t push_job,
    input  wire logic       pop,
    output pixel_job_t      pop_job,
    output queue_status_t   status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    pixel_job_t         entry [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;

    assign status.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = entry[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full && !pop |-> !push)
        else $error("pixel queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pixel queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("pixel queue count out of range");
`endif

endmodule
`default_nettype wire

### hdl/cvls_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvls_back
// Gray conversion: 256*(sample-black)/(white-black), clamped, by a
// restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvls_back
    import cvls_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire queue_status_t q_status,
    input  wire pixel_job_t    pop_job,
    output logic               pop,
    cvls_out_if.source         pixel
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [9:0]           row_reg, column_reg;
    logic signed [16:0]   num_reg, den_reg;
    logic [16:0]          rem_reg, rem_next;
    logic [16:0]          div_reg;
    logic [GRAY_BITS-1:0] quot_reg, quot_next;
    logic [2:0]           step_reg;

    logic [17:0] rem_shift;
    logic        rem_ge;

    assign pop = (state_reg == ST_IDLE) && !q_status.empty;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign rem_next  = rem_ge ? 17'(rem_shift - {1'b0, div_reg}) : rem_shift[16:0];
    assign quot_next = {quot_reg[GRAY_BITS-2:0], rem_ge};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pop) state_next = ST_PREP;
            ST_PREP:
            begin
                if (den_reg <= 17'sd0 || num_reg <= 17'sd0 || num_reg >= den_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:  if (step_reg == 3'd7) state_next = ST_OUT;
            ST_OUT:  if (pixel.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                row_reg    <= pop_job.row;
                column_reg <= pop_job.column;
                num_reg    <= 17'(pop_job.sample) - 17'(cfg.black_level);
                den_reg    <= 17'(cfg.white_level) - 17'(cfg.black_level);
            end
            ST_PREP:
            begin
                rem_reg  <= num_reg[16:0];
                div_reg  <= den_reg[16:0];
                step_reg <= '0;
                // A quotient of 256 or more clamps to full white.
                if (den_reg <= 17'sd0 || num_reg <= 17'sd0)
                    quot_reg <= '0;
                else if (num_reg >= den_reg)
                    quot_reg <= GRAY_MAX;
                else
                    quot_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                step_reg <= step_reg + 3'd1;
            end
            ST_OUT:  ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign pixel.valid        = (state_reg == ST_OUT);
    assign pixel.pixel_row    = row_reg;
    assign pixel.pixel_column = column_reg;
    assign pixel.pixel_gray   = quot_reg;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && step_reg == 3'd7 |=> state_reg == ST_OUT)
        else $error("divider did not finish after eight steps");
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> $past(state_reg == ST_PREP) || $past(state_reg == ST_DIV))
        else $error("divider entered without preparation");
`endif

endmodule
`default_nettype wire

### hdl/composite_video_line_slicer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// composite_video_line_slicer_top
// Composite video sync separator with a gray-level pixel stage.
// ----------------------------------------------------------------------------
// The block takes one video sample per cycle whenever its two-entry pixel
// queue has room; while the queue is full every sample waits, sync and
// blanking samples included. Each visible drawing sample becomes a pixel job
// that a bit-serial restoring divider turns into a gray level: a job whose
// result is clamped or zero skips the divide steps, one that needs all eight
// quotient bits runs all eight steps, and each pixel then waits on the output.
// The divider takes no new job before its pixel has left, which sets the
// sustained pixel rate; the sample input stalls once two jobs queue behind it.
// Configuration writes take effect at once and must be made while the block
// is idle. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module composite_video_line_slicer_top
    import cvls_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    cvls_in_if.sink                        video,
    cvls_out_if.source                     pixel,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t          cfg_reg;
    queue_status_t q_status;
    logic          push, pop;
    pixel_job_t    push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_threshold  <= SYNC_THRESHOLD_RESET;
            cfg_reg.min_line_length <= 16'(MIN_LINE_LENGTH_RESET);
            cfg_reg.black_level     <= BLACK_LEVEL_RESET;
            cfg_reg.white_level     <= WHITE_LEVEL_RESET;
            cfg_reg.frame_width     <= FRAME_WIDTH_RESET;
            cfg_reg.frame_height    <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_THRESHOLD:  cfg_reg.sync_threshold  <= $signed(cfg_data);
                REG_MIN_LINE_LENGTH: cfg_reg.min_line_length <= cfg_data;
                REG_BLACK_LEVEL:     cfg_reg.black_level     <= $signed(cfg_data);
                REG_WHITE_LEVEL:     cfg_reg.white_level     <= $signed(cfg_data);
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_data[10:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    cvls_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .video    (video),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    cvls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    cvls_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .pixel    (pixel)
    );

endmodule
`default_nettype wire

### tb/composite_video_line_slicer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// composite_video_line_slicer_top_tb
// Self-checking bench for the composite video line slicer. Sample beats are
// built from sync bursts and picture lines that walk the phase machine through
// blanking, drawing and full frames. A scoreboard mirrors the block's state
// and gray stage and checks every pixel beat field by field, while both
// channels idle at random and registers are reloaded between idle phases.
// ----------------------------------------------------------------------------
module composite_video_line_slicer_top_tb;
    import cvls_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          REPORT_LINES   = 40;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] column;
        logic [7:0] gray;
    } pixel_t;

    class pixel_scoreboard;
        cfg_t        regs;
        bit          in_sync;
        logic [15:0] line_len;
        int          phase;
        logic [10:0] rows;
        pixel_t      due[$];
        int          errors;
        int          inputs_seen;
        int          pixels_seen;
        int          restarts_seen;

        function new();
            regs.sync_threshold  = SYNC_THRESHOLD_RESET;
            regs.min_line_length = 16'(MIN_LINE_LENGTH_RESET);
            regs.black_level     = BLACK_LEVEL_RESET;
            regs.white_level     = WHITE_LEVEL_RESET;
            regs.frame_width     = FRAME_WIDTH_RESET;
            regs.frame_height    = FRAME_HEIGHT_RESET;
            restart();
        endfunction

        function void restart();
            in_sync  = 1'b0;
            line_len = regs.min_line_length;
            phase    = PHASE_START;
            rows     = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                REG_SYNC_THRESHOLD:  regs.sync_threshold  = value;
                REG_MIN_LINE_LENGTH: regs.min_line_length = value;
                REG_BLACK_LEVEL:     regs.black_level     = value;
                REG_WHITE_LEVEL:     regs.white_level     = value;
                REG_FRAME_WIDTH:     regs.frame_width     = value[10:0];
                REG_FRAME_HEIGHT:    regs.frame_height    = value[10:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function int pending();
            return due.size();
        endfunction

        function logic [7:0] gray_of(logic signed [15:0] level);
            longint blk;
            longint wht;
            longint g;
            blk = $signed(regs.black_level);
            wht = $signed(regs.white_level);
            if (wht <= blk)
                return '0;
            // SystemVerilog division truncates toward zero, as the stage does.
            g = (256 * (longint'(level) - blk)) / (wht - blk);
            if (g < 0)
                return '0;
            if (g > longint'(GRAY_MAX))
                return GRAY_MAX;
            return g[7:0];
        endfunction

        function void note_input(logic mode, logic signed [15:0] sample);
            logic [15:0] minlen;
            pixel_t      p;
            inputs_seen++;
            minlen = regs.min_line_length;
            if (mode)
            begin
                restarts_seen++;
                restart();
                return;
            end
            // A full frame freezes everything until the next restart.
            if (rows >= regs.frame_height)
                return;
            if (sample < $signed(regs.sync_threshold))
            begin
                if (!in_sync)
                begin
                    if (phase == PHASE_DRAW)
                        rows = rows + 11'd1;
                    if (phase < PHASE_BLANK && line_len < minlen)
                        phase += PHASE_STEP;
                    if (phase == PHASE_BLANK && line_len > minlen)
                        phase += PHASE_STEP;
                    if (phase == PHASE_DRAW && line_len < minlen)
                        phase += PHASE_STEP;
                    line_len = '0;
                end
                in_sync = 1'b1;
                return;
            end
            in_sync = 1'b0;
            if (phase == PHASE_DRAW && line_len < regs.frame_width)
            begin
                p.row    = rows[9:0];
                p.column = line_len[9:0];
                p.gray   = gray_of(sample);
                due.push_back(p);
            end
            if (line_len != COUNT_MAX)
                line_len++;
        endfunction

        task check_pixel(pixel_t got);
            pixel_t want;
            pixels_seen++;
            if (due.size() == 0)
            begin
                report($sformatf("pixel row %0d column %0d gray %0d with none expected",
                                 got.row, got.column, got.gray));
                return;
            end
            want = due.pop_front();
            if (got.row !== want.row)
                report($sformatf("pixel_row %0d, expected %0d", got.row, want.row));
            if (got.column !== want.column)
                report($sformatf("pixel_column %0d, expected %0d (row %0d)",
                                 got.column, want.column, want.row));
            if (got.gray !== want.gray)
                report($sformatf("pixel_gray %0d, expected %0d (row %0d column %0d)",
                                 got.gray, want.gray, want.row, want.column));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    bit              steady;
    int              beats_sent;
    int              settings_loaded;
    int              idle_cycles;
    pixel_scoreboard sb;

    cvls_in_if  video_if ();
    cvls_out_if pixel_if ();

    composite_video_line_slicer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .video     (video_if),
        .pixel     (pixel_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Pixel sink: ready drops for random bursts unless the run is steady.
    initial
    begin : pixel_sink
        int stall_left;
        stall_left = 0;
        pixel_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!steady && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            pixel_if.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && video_if.valid && video_if.ready)
            sb.note_input(video_if.mode, video_if.sample);
        if (rst_n && pixel_if.valid && pixel_if.ready)
            sb.check_pixel({pixel_if.pixel_row, pixel_if.pixel_column,
                            pixel_if.pixel_gray});
    end

    always @(posedge clk)
    begin
        if ((video_if.valid && video_if.ready) || (pixel_if.valid && pixel_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat on either channel for %0d cycles.", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int rand_between(int lo, int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [15:0] sync_value();
        return 16'(rand_between(-32768, int'($signed(sb.regs.sync_threshold)) - 1));
    endfunction

    // Mostly levels around the black-to-white span, sometimes anything legal.
    function automatic logic signed [15:0] picture_value();
        int thr;
        int lo;
        int hi;
        thr = $signed(sb.regs.sync_threshold);
        if ($urandom_range(0, 3) == 0)
            return 16'(rand_between(thr, 32767));
        lo = int'($signed(sb.regs.black_level)) - 64;
        hi = int'($signed(sb.regs.white_level)) + 64;
        if (hi < lo)
            hi = lo + 128;
        if (lo < thr)
            lo = thr;
        if (hi > 32767)
            hi = 32767;
        return 16'(rand_between(lo, hi));
    endfunction

    function automatic cfg_t make_settings(int thr, int minlen, int blk, int wht,
                                           int width, int height);
        cfg_t c;
        c.sync_threshold  = 16'(thr);
        c.min_line_length = 16'(minlen);
        c.black_level     = 16'(blk);
        c.white_level     = 16'(wht);
        c.frame_width     = 11'(width);
        c.frame_height    = 11'(height);
        return c;
    endfunction

    function automatic cfg_t random_settings();
        int thr;
        int blk;
        int wht;
        thr = rand_between(-3000, 600);
        blk = rand_between(thr - 500, thr + 1500);
        wht = blk + rand_between(-300, 5000);
        return make_settings(thr, $urandom_range(1, 8), blk, wht,
                             $urandom_range(2, 16), $urandom_range(1, 6));
    endfunction

    task automatic beat(bit mode_bit, logic signed [15:0] value);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            video_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
        video_if.valid  <= 1'b1;
        video_if.mode   <= mode_bit;
        video_if.sample <= value;
        do
        begin
            @(posedge clk);
        end
        while (!video_if.ready);
        beats_sent++;
    endtask

    task automatic send_sync(int n);
        repeat (n)
            beat(1'b0, sync_value());
    endtask

    task automatic send_picture(int n);
        repeat (n)
            beat(1'b0, picture_value());
    endtask

    task automatic send_line(int len);
        send_sync($urandom_range(1, 3));
        send_picture(len);
    endtask

    // Restart, three short blanking lines, one long line, then picture rows
    // and a short line that closes the frame.
    task automatic send_frame(int n_rows);
        int minlen;
        int short_hi;
        int row_hi;
        minlen   = sb.regs.min_line_length;
        short_hi = (minlen > 1) ? minlen - 1 : 1;
        row_hi   = minlen + int'(sb.regs.frame_width) + 2;
        if (row_hi > minlen + 40)
            row_hi = minlen + 40;
        beat(1'b1, 16'($urandom));
        repeat (3)
            send_line($urandom_range(1, short_hi));
        send_line(minlen + $urandom_range(1, 3));
        repeat (n_rows)
            send_line(rand_between(minlen, row_hi));
        send_line($urandom_range(1, short_hi));
        send_sync(1);
    endtask

    task automatic send_broken();
        int minlen;
        minlen = sb.regs.min_line_length;
        case ($urandom_range(0, 2))
            0:
            begin
                repeat ($urandom_range(2, 6))
                    send_line($urandom_range(1, 2 * minlen + 2));
            end
            1:
            begin
                // Too few blanking lines before the long one.
                beat(1'b1, 16'($urandom));
                send_line(1);
                send_line(minlen + 2);
                send_line(minlen + 1);
            end
            default:
            begin
                repeat ($urandom_range(1, 8))
                    beat(1'b0, 16'($urandom));
            end
        endcase
    endtask

    // Drop valid and wait until every expected pixel has been seen.
    task automatic hold_sender(bit settle);
        video_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        if (settle)
            repeat (SETTLE_CYCLES)
                @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_settings(cfg_t c);
        hold_sender(1'b1);
        write_reg(REG_SYNC_THRESHOLD, c.sync_threshold);
        write_reg(REG_MIN_LINE_LENGTH, c.min_line_length);
        write_reg(REG_BLACK_LEVEL, c.black_level);
        write_reg(REG_WHITE_LEVEL, c.white_level);
        write_reg(REG_FRAME_WIDTH, 16'(c.frame_width));
        write_reg(REG_FRAME_HEIGHT, 16'(c.frame_height));
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    task automatic run_random_phase(int n_items);
        int stop_at;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at)
        begin
            case ($urandom_range(0, 7))
                0: send_broken();
                1: hold_sender(1'b0);
                default: send_frame($urandom_range(1, int'(sb.regs.frame_height) + 1));
            endcase
        end
    endtask

    initial
    begin
        sb              = new();
        steady          = 1'b0;
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_SYNC_THRESHOLD;
        cfg_data       <= '0;
        video_if.valid  <= 1'b0;
        video_if.mode   <= 1'b0;
        video_if.sample <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hand-built frame: threshold edge, clamping, truncation, a column
        // past the frame edge and a frame that fills up.
        load_settings(make_settings(100, 3, 1000, 2000, 4, 2));
        beat(1'b1, 16'sh1234);
        beat(1'b0, 16'sd99);
        beat(1'b0, 16'sd100);
        beat(1'b0, -16'sd32768);
        beat(1'b0, 16'sd5000);
        beat(1'b0, 16'sd200);
        beat(1'b0, 16'sd99);
        beat(1'b0, 16'sd32767);
        beat(1'b0, 16'sd0);
        repeat (4)
            beat(1'b0, 16'sd3000);
        beat(1'b0, 16'sd50);
        beat(1'b0, 16'sd999);
        beat(1'b0, 16'sd1000);
        beat(1'b0, 16'sd2000);
        beat(1'b0, 16'sd1500);
        beat(1'b0, 16'sd32767);
        beat(1'b0, -16'sd5);
        beat(1'b0, 16'sd1004);
        beat(1'b0, 16'sd99);
        beat(1'b0, 16'sd1999);
        beat(1'b1, 16'sd0);
        beat(1'b0, 16'sd99);

        // White at or below black gives a gray of zero.
        load_settings(make_settings(-100, 2, 500, 400, 3, 2));
        send_frame(2);
        load_settings(make_settings(-100, 2, 700, 700, 1, 2));
        send_frame(2);

        // Register extremes.
        load_settings(make_settings(-32768, 1, 0, 1, 1, 1024));
        beat(1'b1, 16'sd0);
        repeat (20)
            beat(1'b0, 16'($urandom));
        load_settings(make_settings(32767, 2, -32768, 32767, 1024, 1));
        send_frame(2);
        load_settings(make_settings(-32767, 3, -32768, 32767, 16, 3));
        send_frame(3);
        send_frame(4);

        // Frame limits above 1024 columns and rows.
        load_settings(make_settings(0, 2, 0, 1000, 1100, 1030));
        send_frame(2);

        repeat (6)
        begin
            load_settings(random_settings());
            run_random_phase(40);
        end

        load_settings(random_settings());
        steady = 1'b1;
        run_random_phase(40);
        hold_sender(1'b1);

        $display("Run covered %0d sample beats, %0d restarts and %0d pixels",
                 sb.inputs_seen, sb.restarts_seen, sb.pixels_seen);
        $display("across %0d register settings, with %0d mismatches.",
                 settings_loaded, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hdl/cvls_pkg.sv
hdl/cvls_stream_if.sv
hdl/cvls_front.sv
hdl/cvls_queue.sv
hdl/cvls_back.sv
hdl/composite_video_line_slicer_top.sv
tb/composite_video_line_slicer_top_tb.sv
